>>> rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and codes for the sorted string table.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int KEY_W   = 160;
  localparam int HI_W    = 64;
  localparam int MID_W   = 64;
  localparam int LO_W    = 32;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;
  localparam int IDXIN_W = 4;
  localparam int CNTO_W  = 5;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

  // outcome of one key compare: stored entry against request key
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

>>> rtl/sst_cmp.sv
// ----------------------------------------------------------------------------
// sst_cmp
// Shared 160-bit unsigned key comparator.
// ----------------------------------------------------------------------------
module sst_cmp
  import sst_pkg::*;
(
  input  logic [KEY_W-1:0] entry_key,
  input  logic [KEY_W-1:0] req_key,
  output cmp_res_t         res
);

  // big-endian byte order makes string order a plain unsigned compare
  assign res.lt = entry_key < req_key;
  assign res.eq = entry_key == req_key;

endmodule

>>> rtl/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// Single write, single read key store with registered read data.
// ----------------------------------------------------------------------------
module sst_ram
  import sst_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [KEY_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [KEY_W-1:0] rdata
);

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sorted_string_table.sv
// ----------------------------------------------------------------------------
// sorted_string_table
// Sorted table of up to CAPACITY 20-byte keys kept in one key store and
// walked one entry at a time by a small sequencer and a shared comparator.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------------
//  in_     | input     | in_valid / in_ready  | kind, key (hi/mid/lo), index_in
//  out_    | output    | out_valid / out_ready| status, found_index, entry_count,
//          |           |                      | key (hi/mid/lo) read by get
//
// Each entry visited takes a store read (S_RD), then a compare and optional
// move through the single store port (S_CMP). Insert walks down from the
// top entry to the slot, search and remove walk up from entry 0; get reads
// one entry, and clear, full insert and unknown kinds visit none.
// Reset empties the table at once; the stored keys are not cleared.
// A finished result waits in the output register while the next request is
// taken; the sequencer only stalls at the end of a request if that register
// is still occupied.
// ----------------------------------------------------------------------------
module sorted_string_table
  import sst_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [HI_W-1:0]    in_key_hi,
  input  logic [MID_W-1:0]   in_key_mid,
  input  logic [LO_W-1:0]    in_key_lo,
  input  logic [IDXIN_W-1:0] in_index_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  out_status,
  output logic [IDXIN_W-1:0] out_found_index,
  output logic [CNTO_W-1:0]  out_entry_count,
  output logic [HI_W-1:0]    out_key_hi,
  output logic [MID_W-1:0]   out_key_mid,
  output logic [LO_W-1:0]    out_key_lo
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > IDXIN_W) ? CW : IDXIN_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CMP  = 5'b00100,
    S_PUT  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;       // entry being visited
  logic                found_r, found_nxt;   // remove: match already seen
  logic                out_valid_r, out_valid_nxt;

  // request and working result
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [STAT_W-1:0]   stat_r, stat_nxt;
  logic [IW-1:0]       pos_r, pos_nxt;
  logic [KEY_W-1:0]    rkey_r, rkey_nxt;

  // output register
  logic [STAT_W-1:0]   o_stat_r, o_stat_nxt;
  logic [IDXIN_W-1:0]  o_pos_r, o_pos_nxt;
  logic [CNTO_W-1:0]   o_cnt_r, o_cnt_nxt;
  logic [KEY_W-1:0]    o_key_r, o_key_nxt;

  // store port
  logic                ram_we, ram_re;
  logic [IW-1:0]       ram_waddr;
  logic [KEY_W-1:0]    ram_wdata, ram_rdata;
  cmp_res_t            cmp;

  logic                in_acc, last, slot_free;

  sst_ram #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  sst_cmp u_cmp (
    .entry_key (ram_rdata),
    .req_key   (key_r),
    .res       (cmp)
  );

  assign in_ready  = state_r == S_IDLE;
  assign in_acc    = in_valid && in_ready;
  assign last      = (CW'(idx_r) + CW'(1)) == count_r;
  assign slot_free = !out_valid_r || out_ready;
  assign ram_re    = state_r == S_RD;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    stat_nxt      = stat_r;
    pos_nxt       = pos_r;
    rkey_nxt      = rkey_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_stat_nxt    = o_stat_r;
    o_pos_nxt     = o_pos_r;
    o_cnt_nxt     = o_cnt_r;
    o_key_nxt     = o_key_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = ram_rdata;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // latch the request, start every result from a clean slate
          kind_nxt  = in_kind;
          key_nxt   = {in_key_hi, in_key_mid, in_key_lo};
          stat_nxt  = ST_OK;
          pos_nxt   = '0;
          rkey_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = S_FIN;
          case (in_kind)
            KIND_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                stat_nxt = ST_FULL;
              end else if (count_r == '0) begin
                // empty table: drop the key straight into slot 0
                state_nxt = S_PUT;
              end else begin
                idx_nxt   = IW'(count_r - CW'(1));
                state_nxt = S_RD;
              end
            end
            KIND_REMOVE, KIND_SEARCH: begin
              if (count_r == '0) begin
                stat_nxt = ST_NOT_FOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_RD;
              end
            end
            KIND_GET: begin
              if (XW'(in_index_in) < XW'(count_r)) begin
                idx_nxt   = IW'(in_index_in);
                state_nxt = S_RD;
              end else begin
                stat_nxt = ST_RANGE;
              end
            end
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              // unused kinds leave the table alone
            end
          endcase
        end
      end

      S_RD: begin
        state_nxt = S_CMP;
      end

      S_CMP: begin
        case (kind_r)
          KIND_INSERT: begin
            if (!cmp.lt) begin
              // entry not below key: move it up one slot
              ram_we    = 1'b1;
              ram_waddr = IW'(idx_r + IW'(1));
              if (idx_r == '0) begin
                pos_nxt   = '0;
                state_nxt = S_PUT;
              end else begin
                idx_nxt   = idx_r - IW'(1);
                state_nxt = S_RD;
              end
            end else begin
              // first smaller entry found: key goes right above it
              ram_we    = 1'b1;
              ram_waddr = IW'(idx_r + IW'(1));
              ram_wdata = key_r;
              pos_nxt   = IW'(idx_r + IW'(1));
              count_nxt = count_r + CW'(1);
              state_nxt = S_FIN;
            end
          end
          KIND_REMOVE: begin
            if (found_r) begin
              // close the gap behind the removed entry
              ram_we    = 1'b1;
              ram_waddr = idx_r - IW'(1);
            end else if (cmp.eq) begin
              found_nxt = 1'b1;
              pos_nxt   = idx_r;
            end
            if (last) begin
              if (found_r || cmp.eq) begin
                count_nxt = count_r - CW'(1);
              end else begin
                stat_nxt = ST_NOT_FOUND;
              end
              state_nxt = S_FIN;
            end else begin
              idx_nxt   = idx_r + IW'(1);
              state_nxt = S_RD;
            end
          end
          KIND_SEARCH: begin
            if (cmp.eq) begin
              pos_nxt   = idx_r;
              state_nxt = S_FIN;
            end else if (last) begin
              stat_nxt  = ST_NOT_FOUND;
              state_nxt = S_FIN;
            end else begin
              idx_nxt   = idx_r + IW'(1);
              state_nxt = S_RD;
            end
          end
          KIND_GET: begin
            rkey_nxt  = ram_rdata;
            pos_nxt   = idx_r;
            state_nxt = S_FIN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = key_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // hold until the output register can take the result
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_stat_nxt    = stat_r;
          o_pos_nxt     = IDXIN_W'(pos_r);
          o_cnt_nxt     = CNTO_W'(count_r);
          o_key_nxt     = rkey_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    stat_r   <= stat_nxt;
    pos_r    <= pos_nxt;
    rkey_r   <= rkey_nxt;
    o_stat_r <= o_stat_nxt;
    o_pos_r  <= o_pos_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_key_r  <= o_key_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = o_stat_r;
  assign out_found_index = o_pos_r;
  assign out_entry_count = o_cnt_r;
  assign out_key_hi      = o_key_r[KEY_W-1 -: HI_W];
  assign out_key_mid     = o_key_r[LO_W +: MID_W];
  assign out_key_lo      = o_key_r[LO_W-1:0];

  // table never grows past its capacity
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a full report only comes from a full table
  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == CNTO_W'(CAPACITY))
    else $error("full status with room left");

  // out of range get returns nothing
  a_range_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_RANGE |->
      out_found_index == '0 && o_key_r == '0)
    else $error("range error carries data");

  // one request at a time: sequencer busy right after a request is taken
  a_busy_after : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule
